// File: src/bbsd_pkg.sv
`default_nettype none
package bbsd_pkg;

  // Screen and ray geometry
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int RAY_COUNT     = 128;
  localparam int RAY_AW        = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1;

  // Depth at or below 0.1 world units (Q8) drops the sprite
  localparam int NEAR_LIMIT = 25;
  localparam int HALF_H     = SCREEN_HEIGHT / 2;
  localparam int COL_BIAS   = SCREEN_WIDTH * 128;

  // floor(px * RAY_COUNT / SCREEN_WIDTH) as multiply by reciprocal
  localparam int RECIP_SHIFT = 32;
  localparam longint RAY_RECIP =
    ((longint'(RAY_COUNT) << RECIP_SHIFT) + longint'(SCREEN_WIDTH) - 1) /
    longint'(SCREEN_WIDTH);

  // Shared divider sizes
  localparam int NUM_W = 54;
  localparam int DEN_W = 36;

  typedef enum logic [1:0] {
    CMD_PLACE = 2'd0,
    CMD_DEPTH = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_FOCAL      = 2'd0,
    REG_SPRITE_SZ  = 2'd1,
    REG_TILE_SZ    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_SIDE = 2'd0,
    DIV_COL  = 2'd1,
    DIV_HALF = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_ROT,
    ST_SCALE,
    ST_DIV,
    ST_WAIT,
    ST_PLACE,
    ST_QUERY,
    ST_OUT
  } state_t;

  // Saturate a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [55:0] v);
    if (v > 56'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -56'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: src/billboard_sprite_depth_overlay_unit.sv
// Channel   Direction  Handshake            Payload
// in        receive    in_valid / in_stall  command, positions, trig, ray depth, pixel
// out       send       out_valid/ out_stall sprite_shown, rect_left/top/size, draw_pixel
// cfg       receive    cfg_write            cfg_index, cfg_data
// Place: three 54-step passes of the shared divider; a too-near sprite skips them.
// Depth write goes straight to the output. Query: one ray memory read.
// One word is worked at a time; a finished word waits in the output register
// while the next word is taken. Reset (rst, synchronous) clears the sprite, state
// and out_valid and loads default configuration; ray depths undefined until written.
`default_nettype none
module billboard_sprite_depth_overlay_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic signed [23:0] sprite_x,
  input  wire logic signed [23:0] sprite_y,
  input  wire logic signed [23:0] player_x,
  input  wire logic signed [23:0] player_y,
  input  wire logic signed [15:0] sine_view,
  input  wire logic signed [15:0] cosine_view,
  input  wire logic [6:0]         ray_index,
  input  wire logic [23:0]        wall_depth,
  input  wire logic [9:0]         pixel_x,
  input  wire logic [8:0]         pixel_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    sprite_shown,
  output logic signed [15:0]      rect_left,
  output logic signed [15:0]      rect_top,
  output logic [14:0]             rect_size,
  output logic                    draw_pixel,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import bbsd_pkg::*;

  state_t state, state_next;
  div_sel_t div_sel;

  // configuration
  logic [23:0] focal, sprite_sz, tile_sz;

  // stored sprite
  logic [23:0]        spr_depth;
  logic signed [15:0] spr_left, spr_top;
  logic [14:0]        spr_side;
  logic               spr_valid;

  // captured input word
  logic signed [24:0] sx, sy;
  logic signed [15:0] sn, cs;
  logic [9:0]         px;
  logic [8:0]         py;

  // pipeline
  logic signed [40:0] prod_a, prod_b, prod_c, prod_d;
  logic signed [41:0] rot_d, rot_o;
  logic signed [27:0] depth, off;
  logic               near;
  logic [47:0]        side_num;
  logic signed [52:0] off_prod;
  logic [43:0]        depth_k;
  logic [36:0]        half_num;
  logic signed [54:0] col_num, col_abs;
  logic [NUM_W-1:0]   q_side, q_col, q_half;

  // result staging
  logic               res_shown, res_draw;
  logic signed [15:0] res_left, res_top;
  logic [14:0]        res_size;

  // control
  logic in_accept, div_start, load_out, ram_we;

  // divider
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             div_done;

  // ray memory
  logic [63:0]       ray_prod;
  logic [RAY_AW-1:0] ray_addr;
  logic [23:0]       ray_rd;

  // place final math
  logic [14:0]        side;
  logic signed [54:0] col_s;
  logic [8:0]         halfline_w;
  logic [12:0]        floor_row;
  logic signed [15:0] left_v, top_v;

  // query math
  logic signed [17:0] pxs, pys, left_end, top_end;
  logic               hit;

  assign in_accept = in_valid && !in_stall;

  // control decode
  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = (state == ST_DIV);
    load_out  = (state == ST_OUT) && (!out_valid || !out_stall);
    ram_we    = in_accept && (command == CMD_DEPTH) &&
                ({25'b0, ray_index} < 32'(RAY_COUNT));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (command)
            CMD_PLACE: state_next = ST_PROD;
            CMD_QUERY: state_next = ST_QUERY;
            default:   state_next = ST_OUT;
          endcase
        end
      end
      ST_PROD:  state_next = ST_ROT;
      ST_ROT:   state_next = near ? ST_OUT : ST_SCALE;
      ST_SCALE: state_next = ST_DIV;
      ST_DIV:   state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          state_next = (div_sel == DIV_HALF) ? ST_PLACE : ST_DIV;
        end
      end
      ST_PLACE: state_next = ST_OUT;
      ST_QUERY: state_next = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // rotation into view space
  assign rot_d = 42'(prod_a) - 42'(prod_b);
  assign rot_o = 42'(prod_c) + 42'(prod_d);
  assign near  = ($signed(rot_d[41:14]) <= 28'sd25);

  // column numerator and magnitude
  assign col_num = {{2{off_prod[52]}}, off_prod} + {11'b0, depth_k};
  assign col_abs = col_num[54] ? -col_num : col_num;

  // divider operands
  always_comb begin
    case (div_sel)
      DIV_SIDE: begin
        div_num = {6'b0, side_num};
        div_den = {1'b0, depth[26:0], 8'b0};
      end
      DIV_COL: begin
        div_num = col_abs[NUM_W-1:0];
        div_den = {1'b0, depth[26:0], 8'b0};
      end
      default: begin
        div_num = {17'b0, half_num};
        div_den = {8'b0, depth[26:0], 1'b0};
      end
    endcase
  end

  bbsd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ray slot of the pixel column
  assign ray_prod = 64'(pixel_x) * 64'(RAY_RECIP);
  assign ray_addr = ray_prod[RECIP_SHIFT +: RAY_AW];

  bbsd_ram #(.WIDTH(24), .DEPTH(RAY_COUNT)) u_ray_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ray_index[RAY_AW-1:0]),
    .wdata (wall_depth),
    .raddr (ray_addr),
    .rdata (ray_rd)
  );

  // projection of the kept sprite
  always_comb begin
    side       = (q_side > NUM_W'(32767)) ? 15'h7FFF : q_side[14:0];
    col_s      = col_num[54] ? -$signed({1'b0, q_col}) : $signed({1'b0, q_col});
    halfline_w = (q_half > NUM_W'(HALF_H)) ? 9'(HALF_H) : q_half[8:0];
    floor_row  = 13'(HALF_H) + 13'(halfline_w);
    left_v     = sat16({col_s[54], col_s} - 56'(side >> 1));
    top_v      = sat16(56'(floor_row) - 56'(side));
  end

  // pixel coverage against the stored square
  always_comb begin
    pxs      = {8'b0, px};
    pys      = {9'b0, py};
    left_end = 18'(spr_left) + 18'(spr_side);
    top_end  = 18'(spr_top) + 18'(spr_side);
    hit = spr_valid &&
          ({22'b0, px} < 32'(SCREEN_WIDTH)) && ({23'b0, py} < 32'(SCREEN_HEIGHT)) &&
          (pxs >= 18'(spr_left)) && (pxs < left_end) &&
          (pys >= 18'(spr_top)) && (pys < top_end) &&
          (spr_depth <= ray_rd);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_sel   <= DIV_SIDE;
      out_valid <= 1'b0;
      spr_valid <= 1'b0;
      spr_depth <= '0;
      spr_left  <= '0;
      spr_top   <= '0;
      spr_side  <= '0;
      focal     <= 24'd141891;
      sprite_sz <= 24'd8192;
      tile_sz   <= 24'd16384;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_FOCAL:     focal     <= cfg_data;
          REG_SPRITE_SZ: sprite_sz <= cfg_data;
          REG_TILE_SZ:   tile_sz   <= cfg_data;
          default:       ;
        endcase
      end
      if (state == ST_SCALE) begin
        div_sel <= DIV_SIDE;
      end else if (state == ST_WAIT && div_done) begin
        case (div_sel)
          DIV_SIDE: div_sel <= DIV_COL;
          DIV_COL:  div_sel <= DIV_HALF;
          default:  div_sel <= DIV_SIDE;
        endcase
      end
      if (state == ST_ROT && near) begin
        spr_valid <= 1'b0;
        spr_depth <= '0;
        spr_left  <= '0;
        spr_top   <= '0;
        spr_side  <= '0;
      end else if (state == ST_PLACE) begin
        spr_valid <= 1'b1;
        spr_depth <= (depth[26:24] != 3'b0) ? 24'hFFFFFF : depth[23:0];
        spr_left  <= left_v;
        spr_top   <= top_v;
        spr_side  <= side;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sx <= 25'(sprite_x) - 25'(player_x);
      sy <= 25'(sprite_y) - 25'(player_y);
      sn <= sine_view;
      cs <= cosine_view;
      px <= pixel_x;
      py <= pixel_y;
      res_shown <= 1'b0;
      res_draw  <= 1'b0;
      res_left  <= '0;
      res_top   <= '0;
      res_size  <= '0;
    end
    if (state == ST_PROD) begin
      prod_a <= sx * cs;
      prod_b <= sy * sn;
      prod_c <= sx * sn;
      prod_d <= sy * cs;
    end
    if (state == ST_ROT) begin
      depth <= rot_d[41:14];
      off   <= rot_o[41:14];
    end
    if (state == ST_SCALE) begin
      side_num <= 48'(sprite_sz) * 48'(focal);
      off_prod <= off * $signed({1'b0, focal});
      depth_k  <= 44'(depth[26:0]) * 44'(COL_BIAS);
      half_num <= 37'(tile_sz) * 37'(SCREEN_HEIGHT);
    end
    if (state == ST_WAIT && div_done) begin
      case (div_sel)
        DIV_SIDE: q_side <= div_quo;
        DIV_COL:  q_col  <= div_quo;
        default:  q_half <= div_quo;
      endcase
    end
    if (state == ST_PLACE) begin
      res_shown <= 1'b1;
      res_left  <= left_v;
      res_top   <= top_v;
      res_size  <= side;
    end
    if (state == ST_QUERY) begin
      res_draw <= hit;
    end
    if (load_out) begin
      sprite_shown <= res_shown;
      rect_left    <= res_left;
      rect_top     <= res_top;
      rect_size    <= res_size;
      draw_pixel   <= res_draw;
    end
  end

endmodule
`default_nettype wire

// File: src/bbsd_ram.sv
`default_nettype none
module bbsd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/bbsd_div.sv
`default_nettype none
module bbsd_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [bbsd_pkg::NUM_W-1:0] num,
  input  wire logic [bbsd_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic      [bbsd_pkg::NUM_W-1:0] quo
);
  import bbsd_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] shreg;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Restoring step: one quotient bit per cycle
  assign trial = {rem, shreg[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};
  assign quo   = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      run   <= 1'b1;
      done  <= 1'b0;
      cnt   <= '0;
      shreg <= num;
      rem   <= '0;
    end else if (run) begin
      rem   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      shreg <= {shreg[NUM_W-2:0], fits};
      cnt   <= cnt + 1'b1;
      if (cnt == CNT_W'(NUM_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: src/bbsd_checker.sv
`default_nettype none
module bbsd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               sprite_shown,
  input wire logic signed [15:0] rect_left,
  input wire logic signed [15:0] rect_top,
  input wire logic [14:0]        rect_size,
  input wire logic               draw_pixel
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // one word at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  // place and query results never mix
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(sprite_shown && draw_pixel))
    else $error("place and query flags both set");

  // a dropped sprite reports an empty rectangle
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sprite_shown |-> rect_size == 15'd0 && rect_left == 16'sd0 &&
                                   rect_top == 16'sd0)
    else $error("rectangle set without a shown sprite");

endmodule

bind billboard_sprite_depth_overlay_unit bbsd_checker u_bbsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sprite_shown (sprite_shown),
  .rect_left    (rect_left),
  .rect_top     (rect_top),
  .rect_size    (rect_size),
  .draw_pixel   (draw_pixel)
);
`default_nettype wire

// File: tb/sv/tb_billboard_sprite_depth_overlay_unit.sv
`default_nettype none
module tb_billboard_sprite_depth_overlay_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bbsd_pkg::*;

  // Command code the block does not decode
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         command;
    logic signed [23:0] sprite_x, sprite_y, player_x, player_y;
    logic signed [15:0] sine_view, cosine_view;
    logic [6:0]         ray_index;
    logic [23:0]        wall_depth;
    logic [9:0]         pixel_x;
    logic [8:0]         pixel_y;
  } overlay_cmd_t;

  typedef struct {
    logic               sprite_shown;
    logic signed [15:0] rect_left, rect_top;
    logic [14:0]        rect_size;
    logic               draw_pixel;
  } overlay_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic signed [23:0] sprite_x = '0, sprite_y = '0, player_x = '0, player_y = '0;
  logic signed [15:0] sine_view = '0, cosine_view = '0;
  logic [6:0] ray_index = '0;
  logic [23:0] wall_depth = '0;
  logic [9:0] pixel_x = '0;
  logic [8:0] pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic sprite_shown;
  logic signed [15:0] rect_left, rect_top;
  logic [14:0] rect_size;
  logic draw_pixel;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  billboard_sprite_depth_overlay_unit u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  longint m_focal, m_sprite_sz, m_tile_sz;
  logic [23:0] m_depth;
  logic signed [15:0] m_left, m_top;
  logic [14:0] m_side;
  logic m_valid;
  logic [23:0] m_rays [RAY_COUNT];

  overlay_res_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint sat16_l(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Rotate, project and store, or drop when too close
  function automatic void project_sprite(overlay_cmd_t c);
    longint sx, sy, sn, cs, dep, off, den, side, column, halfline;
    sx = longint'(c.sprite_x) - longint'(c.player_x);
    sy = longint'(c.sprite_y) - longint'(c.player_y);
    sn = c.sine_view;
    cs = c.cosine_view;
    dep = (sx * cs - sy * sn) >>> 14;
    off = (sx * sn + sy * cs) >>> 14;
    if (dep <= NEAR_LIMIT) begin
      m_valid = 1'b0; m_depth = '0; m_left = '0; m_top = '0; m_side = '0;
      return;
    end
    den = dep * 256;
    side = (m_sprite_sz * m_focal) / den;
    if (side > 32767) side = 32767;
    column = (off * m_focal + longint'(SCREEN_WIDTH) * 128 * dep) / den;
    halfline = (m_tile_sz * SCREEN_HEIGHT) / (dep * 2);
    if (halfline > HALF_H) halfline = HALF_H;
    m_left = 16'(sat16_l(column - side / 2));
    m_top = 16'(sat16_l(HALF_H + halfline - side));
    m_side = 15'(side);
    m_depth = (dep > 64'hFFFFFF) ? 24'hFFFFFF : 24'(dep);
    m_valid = 1'b1;
  endfunction

  function automatic logic pixel_covered(overlay_cmd_t c);
    longint px, py, ray;
    px = c.pixel_x;
    py = c.pixel_y;
    if (!m_valid || px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT) return 1'b0;
    if (px < m_left || px >= longint'(m_left) + longint'(m_side)) return 1'b0;
    if (py < m_top || py >= longint'(m_top) + longint'(m_side)) return 1'b0;
    ray = (px * RAY_COUNT) / SCREEN_WIDTH;
    return m_depth <= m_rays[ray];
  endfunction

  function automatic overlay_res_t predict_overlay(overlay_cmd_t c);
    overlay_res_t r;
    r = '{default: '0};
    case (c.command)
      CMD_PLACE: begin
        project_sprite(c);
        r.sprite_shown = m_valid;
        r.rect_left = m_left;
        r.rect_top = m_top;
        r.rect_size = m_side;
      end
      CMD_DEPTH: m_rays[c.ray_index] = c.wall_depth;
      CMD_QUERY: r.draw_pixel = pixel_covered(c);
      default: ;
    endcase
    return r;
  endfunction

  // Send one word, predicting its result
  task automatic send_word(overlay_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pending_results.push_back(predict_overlay(c));
    in_valid <= 1'b1;
    command <= c.command;
    sprite_x <= c.sprite_x; sprite_y <= c.sprite_y;
    player_x <= c.player_x; player_y <= c.player_y;
    sine_view <= c.sine_view; cosine_view <= c.cosine_view;
    ray_index <= c.ray_index; wall_depth <= c.wall_depth;
    pixel_x <= c.pixel_x; pixel_y <= c.pixel_y;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] value);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FOCAL: m_focal = value;
      REG_SPRITE_SZ: m_sprite_sz = value;
      REG_TILE_SZ: m_tile_sz = value;
      default: ;
    endcase
  endtask

  // Word builders
  function automatic overlay_cmd_t place_word(longint sx, longint sy, longint px,
                                              longint py, longint sn, longint cs);
    overlay_cmd_t c;
    c = '{default: '0};
    c.command = CMD_PLACE;
    c.sprite_x = 24'(sx); c.sprite_y = 24'(sy);
    c.player_x = 24'(px); c.player_y = 24'(py);
    c.sine_view = 16'(sn); c.cosine_view = 16'(cs);
    return c;
  endfunction

  function automatic overlay_cmd_t depth_word(int idx, logic [23:0] d);
    overlay_cmd_t c;
    c = '{default: '0};
    c.command = CMD_DEPTH;
    c.ray_index = 7'(idx);
    c.wall_depth = d;
    return c;
  endfunction

  function automatic overlay_cmd_t query_word(int px, int py);
    overlay_cmd_t c;
    c = '{default: '0};
    c.command = CMD_QUERY;
    c.pixel_x = 10'(px);
    c.pixel_y = 9'(py);
    return c;
  endfunction

  // Plausible place: sprite ahead of a player, view mostly forward
  function automatic overlay_cmd_t random_place();
    longint px, py, cs, sn;
    overlay_cmd_t c;
    px = longint'($urandom_range(2097152)) - 1048576;
    py = longint'($urandom_range(2097152)) - 1048576;
    cs = $urandom_range(16384, 9000);
    sn = longint'($urandom_range(16000)) - 8000;
    if ($urandom_range(9) == 0) cs = -cs;
    c = place_word(px + $urandom_range(6000, 0), py + longint'($urandom_range(4000)) - 2000,
                   px, py, sn, cs);
    if ($urandom_range(19) == 0) begin
      c.sprite_x = 24'($urandom); c.sprite_y = 24'($urandom);
      c.sine_view = 16'($urandom); c.cosine_view = 16'($urandom);
    end
    return c;
  endfunction

  // Query aimed at the stored square most of the time
  function automatic overlay_cmd_t random_query();
    int px, py;
    if ($urandom_range(3) != 0 && m_side != 0) begin
      px = int'(m_left) + $urandom_range(int'(m_side));
      py = int'(m_top) + $urandom_range(int'(m_side));
      if (px < 0 || px > 1023) px = $urandom_range(639);
      if (py < 0 || py > 511) py = $urandom_range(479);
    end else begin
      px = $urandom_range(1023);
      py = $urandom_range(511);
    end
    return query_word(px, py);
  endfunction

  task automatic test_no_sprite();
    send_word(query_word(0, 0));
    send_word(query_word(320, 240));
  endtask

  task automatic test_ray_fill();
    for (int i = 0; i < RAY_COUNT; i++)
      send_word(depth_word(i, (i == 0) ? 24'h0 : (i == 127) ? 24'hFFFFFF : 24'($urandom)));
  endtask

  task automatic test_directed();
    // near limit: depth exactly 0.1 dropped, just past kept
    send_word(place_word(25, 0, 0, 0, 0, 16384));
    send_word(place_word(26, 0, 0, 0, 0, 16384));
    send_word(query_word(320, 479));
    send_word(place_word(2560, 0, 0, 0, 0, 16384));
    send_word(query_word(320, 250));
    // depth test: hidden behind a close wall, then visible
    send_word(depth_word(64, 24'd100));
    send_word(query_word(320, 250));
    send_word(depth_word(64, 24'd2560));
    send_word(query_word(320, 250));
    // extremes of positions and trig
    send_word(place_word(8388607, 8388607, -8388608, -8388608, 32767, 32767));
    send_word(place_word(-8388608, 8388607, 8388607, -8388608, -32768, -32768));
    send_word(place_word(8388607, 0, -8388608, 0, 0, 16384));
    send_word(place_word(4096, -3000, 0, 0, -16384, 16384));
    send_word(query_word(1023, 511));
    send_word(query_word(639, 480));
    send_word(query_word(640, 0));
    // unknown command is ignored
    begin
      overlay_cmd_t c;
      c = place_word(2560, 0, 0, 0, 0, 16384);
      c.command = CMD_UNUSED;
      c.ray_index = 7'h7F; c.wall_depth = 24'hFFFFFF;
      c.pixel_x = 10'h3FF; c.pixel_y = 9'h1FF;
      send_word(c);
    end
  endtask

  task automatic test_random(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) send_word(random_place());
      else if (pick < 45) send_word(depth_word($urandom_range(127),
                                   ($urandom_range(1)) ? 24'($urandom_range(30000)) :
                                                         24'($urandom)));
      else if (pick < 97) send_word(random_query());
      else begin
        overlay_cmd_t c;
        c = random_query();
        c.command = CMD_UNUSED;
        send_word(c);
      end
    end
  endtask

  task automatic test_config(logic [23:0] focal, logic [23:0] spr, logic [23:0] tile, int count);
    write_reg(REG_FOCAL, focal);
    write_reg(REG_SPRITE_SZ, spr);
    write_reg(REG_TILE_SZ, tile);
    test_random(count);
  endtask

  // Result checker and output stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected word shown=%0d left=%0d top=%0d size=%0d draw=%0d",
                   $time, sprite_shown, rect_left, rect_top, rect_size, draw_pixel);
          errors++;
        end else begin
          overlay_res_t e;
          e = pending_results.pop_front();
          if (e.sprite_shown !== sprite_shown || e.rect_left !== rect_left ||
              e.rect_top !== rect_top || e.rect_size !== rect_size ||
              e.draw_pixel !== draw_pixel) begin
            $display("%0t mismatch exp shown=%0d left=%0d top=%0d size=%0d draw=%0d",
                     $time, e.sprite_shown, e.rect_left, e.rect_top, e.rect_size,
                     e.draw_pixel);
            $display("%0t          got shown=%0d left=%0d top=%0d size=%0d draw=%0d",
                     $time, sprite_shown, rect_left, rect_top, rect_size, draw_pixel);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    m_focal = 141891; m_sprite_sz = 8192; m_tile_sz = 16384;
    m_depth = '0; m_left = '0; m_top = '0; m_side = '0; m_valid = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_sprite();
    test_ray_fill();
    test_directed();

    test_random(300);
    send_idle_pct = 71;
    test_random(250);
    send_idle_pct = 0; recv_stall_pct = 71;
    test_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 200);
    send_idle_pct = 9; recv_stall_pct = 9;
    test_config(24'h0, 24'h0, 24'h0, 100);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_config(24'd60000, 24'd20000, 24'd4096, 200);
    send_idle_pct = 9; recv_stall_pct = 9;
    test_config(24'd141891, 24'd8192, 24'd16384, 150);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
